// File: rtl/jbds_pkg.sv
// Shared types, character codes and helpers for the JSON block delimiter scanner.
package jbds_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_BLOCK = 2'd0,
    STATUS_CLEAN = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_ERROR = 2'd3
  } status_e;

  // Kind of the block that is currently open.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_OBJECT = 2'd1,
    KIND_ARRAY  = 2'd2
  } open_kind_e;

  // Reported block kind.
  localparam logic BLOCK_OBJECT = 1'b0;
  localparam logic BLOCK_ARRAY  = 1'b1;

  // Character codes.
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;

  // Whitespace is the space character and the control codes from tab to carriage return.
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

// File: rtl/json_block_delimiter_scanner_top.sv
// Top level of the JSON block delimiter scanner: input register, scan logic, result register.
//
// The scanner takes one buffer byte per request and can accept a new request in every
// clock cycle while in_stall_o is low. A request passes through an input register; when
// it advances, the scan state (offset, string and escape flags, bracket depth) is
// updated and any result is written to the result register. A completed block reports
// its kind and its start and end offsets (end is one past the closing bracket); an end
// marker or a zero byte reports the buffer outcome and restarts the offset count at
// zero. Only the first bracket kind of a block is counted for nesting. When a result is
// held by out_stall_i, items that produce no result keep flowing; an item that would
// produce a result waits in the input register.
module json_block_delimiter_scanner_top #(
  parameter int OFFSET_BITS = 16,
  parameter int DEPTH_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        block_kind_o,
  output logic [15:0] block_start_o,
  output logic [15:0] block_end_o
);

  localparam logic [OFFSET_BITS-1:0] PosMax  = {OFFSET_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0]  NestMax = {DEPTH_BITS{1'b1}};

  // Input register.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eob_q;

  // Scan state.
  logic [OFFSET_BITS-1:0] position_q, position_d;
  logic                   in_string_q, in_string_d;
  logic                   escape_q, escape_d;
  jbds_pkg::open_kind_e   open_kind_q, open_kind_d;
  logic [DEPTH_BITS-1:0]  nesting_q, nesting_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   any_block_q, any_block_d;
  logic                   nonspace_q, nonspace_d;
  logic                   overflow_q, overflow_d;

  // Result register.
  logic                   out_vld_q;
  jbds_pkg::status_e      status_q, status_d;
  logic                   kind_q, kind_d;
  logic [OFFSET_BITS-1:0] rstart_q, rstart_d;
  logic [OFFSET_BITS-1:0] rend_q, rend_d;

  logic has_result;
  logic out_free;
  logic advance;
  logic in_take;
  logic is_end;
  logic [7:0] opener;
  logic [7:0] closer;

  // Widened copies for masking offsets down to the 16-bit result fields.
  logic [OFFSET_BITS+15:0] start_ext;
  logic [OFFSET_BITS+15:0] end_ext;

  // Handshake: the register in front advances when its item either makes no result
  // or the result register is free or being emptied.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (out_free || !has_result);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign is_end = eob_q || (byte_q == jbds_pkg::CHAR_NUL);
  assign opener = (open_kind_q == jbds_pkg::KIND_OBJECT) ? jbds_pkg::CHAR_LBRACE
                                                         : jbds_pkg::CHAR_LBRACKET;
  assign closer = (open_kind_q == jbds_pkg::KIND_OBJECT) ? jbds_pkg::CHAR_RBRACE
                                                         : jbds_pkg::CHAR_RBRACKET;

  // Scan step for the item held in the input register.
  always_comb begin
    position_d  = position_q;
    in_string_d = in_string_q;
    escape_d    = escape_q;
    open_kind_d = open_kind_q;
    nesting_d   = nesting_q;
    start_d     = start_q;
    any_block_d = any_block_q;
    nonspace_d  = nonspace_q;
    overflow_d  = overflow_q;
    has_result  = 1'b0;
    status_d    = jbds_pkg::STATUS_BLOCK;
    kind_d      = jbds_pkg::BLOCK_OBJECT;
    rstart_d    = '0;
    rend_d      = '0;

    if (is_end) begin
      // End of buffer: report the outcome and return to the reset state.
      has_result = 1'b1;
      if (overflow_q || nonspace_q) begin
        status_d = jbds_pkg::STATUS_ERROR;
      end else if (!any_block_q) begin
        status_d = jbds_pkg::STATUS_EMPTY;
      end else begin
        status_d = jbds_pkg::STATUS_CLEAN;
      end
      position_d  = '0;
      in_string_d = 1'b0;
      escape_d    = 1'b0;
      open_kind_d = jbds_pkg::KIND_NONE;
      nesting_d   = '0;
      start_d     = '0;
      any_block_d = 1'b0;
      nonspace_d  = 1'b0;
      overflow_d  = 1'b0;
    end else if (overflow_q) begin
      // Bytes after an overflow are dropped until the end of the buffer.
    end else if (position_q == PosMax) begin
      overflow_d = 1'b0 | 1'b1;
    end else begin
      position_d = position_q + 1'b1;
      if (!jbds_pkg::is_space(byte_q)) begin
        nonspace_d = 1'b1;
      end
      if (in_string_q) begin
        // Inside a string only quotes and escapes matter.
        if ((byte_q == jbds_pkg::CHAR_QUOTE) && !escape_q) begin
          in_string_d = 1'b0;
        end
        escape_d = (byte_q == jbds_pkg::CHAR_BACKSLASH) && !escape_q;
      end else if (byte_q == jbds_pkg::CHAR_QUOTE) begin
        in_string_d = 1'b1;
      end else if (open_kind_q == jbds_pkg::KIND_NONE) begin
        // The first bracket outside a string opens a block.
        if (byte_q == jbds_pkg::CHAR_LBRACE) begin
          open_kind_d = jbds_pkg::KIND_OBJECT;
          start_d     = position_q;
          nesting_d   = DEPTH_BITS'(1);
        end else if (byte_q == jbds_pkg::CHAR_LBRACKET) begin
          open_kind_d = jbds_pkg::KIND_ARRAY;
          start_d     = position_q;
          nesting_d   = DEPTH_BITS'(1);
        end
      end else if (byte_q == opener) begin
        if (nesting_q == NestMax) begin
          overflow_d = 1'b1;
        end else begin
          nesting_d = nesting_q + 1'b1;
        end
      end else if ((byte_q == closer) && (nesting_q != '0)) begin
        nesting_d = nesting_q - 1'b1;
        if (nesting_q == DEPTH_BITS'(1)) begin
          // The outermost bracket closed: report the block.
          has_result  = 1'b1;
          status_d    = jbds_pkg::STATUS_BLOCK;
          kind_d      = (open_kind_q == jbds_pkg::KIND_ARRAY) ? jbds_pkg::BLOCK_ARRAY
                                                              : jbds_pkg::BLOCK_OBJECT;
          rstart_d    = start_q;
          rend_d      = position_q + 1'b1;
          open_kind_d = jbds_pkg::KIND_NONE;
          any_block_d = 1'b1;
          nonspace_d  = 1'b0;
          start_d     = '0;
        end
      end
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      eob_q  <= end_of_buffer_i;
    end
  end

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      in_string_q <= 1'b0;
      escape_q    <= 1'b0;
      open_kind_q <= jbds_pkg::KIND_NONE;
      nesting_q   <= '0;
      start_q     <= '0;
      any_block_q <= 1'b0;
      nonspace_q  <= 1'b0;
      overflow_q  <= 1'b0;
    end else if (advance) begin
      position_q  <= position_d;
      in_string_q <= in_string_d;
      escape_q    <= escape_d;
      open_kind_q <= open_kind_d;
      nesting_q   <= nesting_d;
      start_q     <= start_d;
      any_block_q <= any_block_d;
      nonspace_q  <= nonspace_d;
      overflow_q  <= overflow_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_result) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      status_q <= status_d;
      kind_q   <= kind_d;
      rstart_q <= rstart_d;
      rend_q   <= rend_d;
    end
  end

  // Offsets are reported modulo 2^16.
  assign start_ext = {16'b0, rstart_q};
  assign end_ext   = {16'b0, rend_q};

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign block_kind_o  = kind_q;
  assign block_start_o = start_ext[15:0];
  assign block_end_o   = end_ext[15:0];

endmodule
